[src/xml_entity_unescaper_assert.svh]
// Assertion macros for the XML entity unescaper.
// Used inside modules that have clk and arst_n in scope.
`ifndef XML_ENTITY_UNESCAPER_ASSERT_SVH
`define XML_ENTITY_UNESCAPER_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define XEU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define XEU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/xeu_pkg.sv]
// Package for the XML entity unescaper: byte and count types, entity tables.
// No dependencies.
package xeu_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] cnt_t;

	localparam int ENT_COUNT  = 5;
	localparam int NAME_LEN   = 5;
	localparam int HOLD_DEPTH = 4;
	localparam int OUT_DEPTH  = 6;

	localparam byte_t AMP_CHAR = "&";

	// Entity names without the leading '&', padded with zero
	localparam byte_t ENT_NAME [ENT_COUNT][NAME_LEN] = '{
		'{"a", "m", "p", ";", 8'h00},
		'{"l", "t", ";", 8'h00, 8'h00},
		'{"g", "t", ";", 8'h00, 8'h00},
		'{"q", "u", "o", "t", ";"},
		'{"a", "p", "o", "s", ";"}
	};

	localparam cnt_t ENT_LEN [ENT_COUNT] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};

	localparam byte_t ENT_CHAR [ENT_COUNT] = '{"&", "<", ">", "\"", "'"};

endpackage

[src/xml_entity_unescaper.sv]
// XML predefined entity decoder, top level.
// Depends on xeu_pkg and xml_entity_unescaper_assert.svh.
//
//  channel | handshake           | payload
//  --------+---------------------+--------------------------
//  in      | in_valid / in_stall | in_byte, end_of_string
//  out     | out_valid/out_stall | out_byte, last_of_string
//
// An item is decoded combinationally from the input stage register into a
// six-byte result buffer register. An item yielding several results holds the
// buffer until they drain, so plain text runs at one byte per cycle while
// out_stall is low; a failed match stalls the input while the literal bytes
// drain. Reset clears all control state at once.
// Output stall backs up through the buffer to in_stall.
module xml_entity_unescaper (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  xeu_pkg::byte_t in_byte,
	input  logic          end_of_string,
	output logic          out_valid,
	input  logic          out_stall,
	output xeu_pkg::byte_t out_byte,
	output logic          last_of_string
);
	import xeu_pkg::*;

	// input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  eos_s1;

	// decode state
	logic  in_entity_q;
	cnt_t  pcnt_q;
	byte_t pend_q [HOLD_DEPTH];

	// result buffer, shifts toward entry zero
	byte_t rbuf_q [OUT_DEPTH];
	cnt_t  rcnt_q;
	logic  reos_q;

	logic  buf_free, load, pop;

	// decode signals
	logic [ENT_COUNT-1:0] hit, full_e;
	logic  full, live, store, lit, tail, fresh_open;
	byte_t full_char;
	byte_t slot [OUT_DEPTH];
	cnt_t  slot_cnt;

	assign out_valid      = (rcnt_q != 3'd0);
	assign out_byte       = rbuf_q[0];
	assign last_of_string = reos_q && (rcnt_q == 3'd1);
	assign pop            = out_valid && !out_stall;
	assign buf_free       = (rcnt_q == 3'd0) || ((rcnt_q == 3'd1) && !out_stall);
	assign load           = valid_s1 && buf_free;
	assign in_stall       = valid_s1 && !buf_free;

	// input stage register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_string;
		end
	end

	// match held bytes plus the new byte against every entity name
	always_comb begin
		full_char = ENT_CHAR[0];
		for (int e = 0; e < ENT_COUNT; e++) begin
			hit[e] = (cnt_t'(pcnt_q + 3'd1) <= ENT_LEN[e]) &&
				(ENT_NAME[e][pcnt_q] == byte_s1);
			for (int i = 0; i < HOLD_DEPTH; i++) begin
				if ((3'(i) < pcnt_q) && (pend_q[i] != ENT_NAME[e][i])) begin
					hit[e] = 1'b0;
				end
			end
			full_e[e] = hit[e] && (cnt_t'(pcnt_q + 3'd1) == ENT_LEN[e]);
		end
		for (int e = ENT_COUNT - 1; e >= 0; e--) begin
			if (full_e[e]) begin
				full_char = ENT_CHAR[e];
			end
		end
	end

	// result shape: entity char alone, or optional '&'+held bytes then an optional new byte
	always_comb begin
		full       = in_entity_q && (|full_e);
		live       = |hit;
		store      = in_entity_q && !full && live && (pcnt_q < 3'(HOLD_DEPTH));
		lit        = in_entity_q && !full && (!store || eos_s1);
		fresh_open = (!in_entity_q || (!full && !store)) && (byte_s1 == AMP_CHAR);
		if (full) begin
			tail = 1'b0;
		end else if (store) begin
			tail = eos_s1;
		end else begin
			tail = (byte_s1 != AMP_CHAR) || eos_s1;
		end

		if (full) begin
			slot_cnt = 3'd1;
		end else if (lit) begin
			slot_cnt = cnt_t'(pcnt_q + 3'd1 + {2'b00, tail});
		end else begin
			slot_cnt = {2'b00, tail};
		end

		if (full) begin
			slot[0] = full_char;
		end else if (lit) begin
			slot[0] = AMP_CHAR;
		end else begin
			slot[0] = byte_s1;
		end
		for (int i = 1; i <= HOLD_DEPTH; i++) begin
			slot[i] = (lit && (3'(i) <= pcnt_q)) ? pend_q[i-1] : byte_s1;
		end
		slot[OUT_DEPTH-1] = byte_s1;
	end

	// entity state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_entity_q <= 1'b0;
			pcnt_q      <= 3'd0;
		end else if (load) begin
			if (eos_s1) begin
				in_entity_q <= 1'b0;
				pcnt_q      <= 3'd0;
			end else begin
				in_entity_q <= store || fresh_open;
				pcnt_q      <= store ? cnt_t'(pcnt_q + 3'd1) : 3'd0;
			end
		end
	end

	// held name bytes
	always_ff @(posedge clk) begin
		if (load && store) begin
			pend_q[pcnt_q[1:0]] <= byte_s1;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= 3'd0;
			reos_q <= 1'b0;
		end else if (load) begin
			rcnt_q <= slot_cnt;
			reos_q <= eos_s1;
		end else if (pop) begin
			rcnt_q <= cnt_t'(rcnt_q - 3'd1);
		end
	end

	// result buffer data
	always_ff @(posedge clk) begin
		if (load) begin
			rbuf_q <= slot;
		end else if (pop) begin
			for (int i = 0; i < OUT_DEPTH - 1; i++) begin
				rbuf_q[i] <= rbuf_q[i+1];
			end
		end
	end

`include "xml_entity_unescaper_assert.svh"

	`XEU_ASSERT_NOW(a_pcnt_range, 1'b1, pcnt_q <= 3'(HOLD_DEPTH), "held count above depth")
	`XEU_ASSERT_NOW(a_pcnt_closed, !in_entity_q, pcnt_q == 3'd0, "held bytes, entity closed")
	`XEU_ASSERT_NEXT(a_eos_clears, load && eos_s1, !in_entity_q && (pcnt_q == 3'd0), "state kept")
	`XEU_ASSERT_NOW(a_stall_busy, in_stall, valid_s1 && (rcnt_q != 3'd0), "stall, buffer free")

endmodule
